// ===== src/eld_descriptor_parser_macros.svh =====
// Assertion macros shared by the ELD descriptor parser RTL.
`ifndef ELD_DESCRIPTOR_PARSER_MACROS_SVH
`define ELD_DESCRIPTOR_PARSER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ELD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ELD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/eld_pkg.sv =====
// Types and constants of the ELD descriptor parser.
`default_nettype none

package eld_pkg;

   localparam int MAX_NAME_LEN = 16;
   localparam int FIXED_BYTES  = 20;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 120;
   localparam int RSP_USER_W = 3;

   // Record kinds.
   localparam logic [2:0] KIND_SAD    = 3'd0;
   localparam logic [2:0] KIND_HEADER = 3'd1;
   localparam logic [2:0] KIND_PORT   = 3'd2;
   localparam logic [2:0] KIND_VENDOR = 3'd3;
   localparam logic [2:0] KIND_STATUS = 3'd4;

   // Status and error codes.
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_VER   = 2'd1;
   localparam logic [1:0] STAT_NAME_LEN  = 2'd2;
   localparam logic [1:0] STAT_TRUNCATED = 2'd3;

   // Accepted ELD versions.
   localparam logic [4:0] VER_CEA861 = 5'd2;
   localparam logic [4:0] VER_PARTIAL = 5'd31;

   // SAD coding types with special decoding.
   localparam logic [3:0] FMT_LPCM     = 4'd1;
   localparam logic [3:0] FMT_COMP_LO  = 4'd2;
   localparam logic [3:0] FMT_COMP_HI  = 4'd8;
   localparam logic [3:0] FMT_WMAPRO   = 4'd14;
   localparam logic [3:0] FMT_EXTENDED = 4'd15;
   localparam logic [4:0] EXT_FIRST    = 5'd1;
   localparam logic [4:0] EXT_LAST     = 5'd3;
   localparam logic [4:0] EXT_OFFSET   = 5'd14;

   localparam logic [20:0] BITRATE_UNIT = 21'd8000;
   localparam logic [15:0] SPK_ALL      = 16'hFFFF;

   // Special byte positions.
   localparam logic [7:0] POS_VERSION = 8'd0;
   localparam logic [7:0] POS_NAMELEN = 8'd4;
   localparam logic [7:0] POS_SADCNT  = 8'd5;
   localparam logic [7:0] POS_HEADER  = 8'd7;
   localparam logic [7:0] POS_ID_LO   = 8'd8;
   localparam logic [7:0] POS_PORT_ID = 8'd15;
   localparam logic [7:0] POS_VENDOR  = 8'(FIXED_BYTES - 1);
   localparam logic [7:0] POS_SAD     = 8'(FIXED_BYTES);
   localparam logic [7:0] POS_MAX     = 8'd255;

   typedef struct packed {
      logic [2:0]  record_kind;
      logic [1:0]  status;
      logic [3:0]  sad_index;
      logic [4:0]  coding_format;
      logic [3:0]  channels;
      logic [6:0]  rate_mask;
      logic [2:0]  sample_size_mask;
      logic [20:0] peak_bitrate;
      logic [2:0]  profile;
      logic [63:0] info_word;
      logic        last_out;
   } rsp_record_type;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

`default_nettype wire

// ===== src/eld_descriptor_parser.sv =====
// Top level of the ELD descriptor parser: byte decoder and result queue.
//
//   channel | direction | payload
//   req_    | in        | tdata[7:0] ELD byte, tlast final byte of the buffer
//   rsp_    | out       | tuser record kind, tdata record fields, tlast final status
//
// Each byte is decoded in the cycle it is accepted and its records are
// written straight into a four-word result queue, so a byte can be taken
// every cycle. A byte yields at most two words (a record and the status);
// req_tready is high while the queue has room for two. Reset is synchronous
// and clears position, counters, error and the queue. A stalled rsp_ side
// backs up into req_tready once more than two words wait in the queue.
`default_nettype none

`include "eld_descriptor_parser_macros.svh"

module eld_descriptor_parser (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // eld_byte[7:0]
   input  wire  [eld_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire                              req_tlast,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // status[1:0] sad_index[5:2] coding_format[10:6] channels[14:11]
   // rate_mask[21:15] sample_size_mask[24:22] peak_bitrate[45:25]
   // profile[48:46] info_word[112:49] zero fill[119:113]
   output logic [eld_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // record_kind[2:0]
   output logic [eld_pkg::RSP_USER_W-1:0]   rsp_tuser,
   output logic                             rsp_tlast
);
   import eld_pkg::*;

   // Parser state.
   logic [7:0]  pos_ff, pos_in;
   logic [4:0]  nl_ff, nl_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [3:0]  done_ff, done_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  err_ff, err_in;
   logic [63:0] id_ff, id_in;
   logic [7:0]  hdr_ff [8];
   logic [7:0]  sad_ff [2];

   // Result queue.
   rsp_record_type           fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]         count_ff, count_in;

   logic           accept, pop;
   logic [7:0]     b;
   logic [7:0]     rel;
   logic           sad_act;
   logic           has_rec;
   logic [1:0]     push_n;
   logic [1:0]     final_stat;
   logic [6:0]     need;
   logic [3:0]     fmt;
   logic [4:0]     ext;
   logic [15:0]    spk;
   logic [63:0]    hdr_word;
   rsp_record_type rec, stat_rec, first_rec;

   assign accept = req_tvalid && req_tready;
   assign pop    = rsp_tvalid && rsp_tready;
   assign b      = req_tdata;
   assign rel    = pos_ff - POS_SAD;

   assign req_tready = (count_ff <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].record_kind;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last_out;
   assign rsp_tdata  = {7'd0,
                        fifo_ff[rd_ptr_ff].info_word,
                        fifo_ff[rd_ptr_ff].profile,
                        fifo_ff[rd_ptr_ff].peak_bitrate,
                        fifo_ff[rd_ptr_ff].sample_size_mask,
                        fifo_ff[rd_ptr_ff].rate_mask,
                        fifo_ff[rd_ptr_ff].channels,
                        fifo_ff[rd_ptr_ff].coding_format,
                        fifo_ff[rd_ptr_ff].sad_index,
                        fifo_ff[rd_ptr_ff].status};

   // Header word; byte 7 is the byte arriving now.
   always_comb begin
      spk = (b[6:0] == 7'd0) ? SPK_ALL : {9'd0, b[6:0]};
      hdr_word = {15'd0, hdr_ff[2], spk, hdr_ff[6], 1'b0, hdr_ff[5][7:4],
                  hdr_ff[5][3:2], hdr_ff[5][1], hdr_ff[5][0], hdr_ff[4][7:5],
                  hdr_ff[0][7:3]};
   end

   // Byte decoding and next state.
   always_comb begin
      pos_in   = pos_ff;
      nl_in    = nl_ff;
      cnt_in   = cnt_ff;
      done_in  = done_ff;
      phase_in = phase_ff;
      err_in   = err_ff;
      id_in    = id_ff;
      has_rec  = 1'b0;
      rec      = '0;
      fmt      = sad_ff[0][6:3];
      ext      = b[7:3];
      sad_act  = (pos_ff >= POS_SAD) && (rel >= {3'd0, nl_ff}) && (done_ff < cnt_ff);

      if (pos_ff < POS_ID_LO) begin
         if (pos_ff == POS_VERSION) begin
            if (b[7:3] != VER_CEA861 && b[7:3] != VER_PARTIAL && err_ff == STAT_OK) begin
               err_in = STAT_BAD_VER;
            end
         end else if (pos_ff == POS_NAMELEN) begin
            nl_in = b[4:0];
            if (b[4:0] > 5'(MAX_NAME_LEN) && err_ff == STAT_OK) begin
               err_in = STAT_NAME_LEN;
            end
         end else if (pos_ff == POS_SADCNT) begin
            cnt_in = b[7:4];
         end else if (pos_ff == POS_HEADER && err_ff == STAT_OK) begin
            has_rec = 1'b1;
            rec.record_kind = KIND_HEADER;
            rec.info_word = hdr_word;
         end
      end else if (pos_ff < POS_SAD) begin
         id_in = {b, id_ff[63:8]};
         if (pos_ff == POS_PORT_ID && err_ff == STAT_OK) begin
            has_rec = 1'b1;
            rec.record_kind = KIND_PORT;
            rec.info_word = id_in;
         end else if (pos_ff == POS_VENDOR && err_ff == STAT_OK) begin
            has_rec = 1'b1;
            rec.record_kind = KIND_VENDOR;
            rec.info_word = {32'd0, id_in[63:32]};
         end
      end else if (sad_act) begin
         // The phase counter tracks the byte within the current SAD.
         if (phase_ff == 2'd2) begin
            phase_in = 2'd0;
            done_in  = done_ff + 4'd1;
            if (err_ff == STAT_OK) begin
               has_rec = 1'b1;
               rec.record_kind = KIND_SAD;
               rec.sad_index = done_ff;
               rec.channels = {1'b0, sad_ff[0][2:0]} + 4'd1;
               rec.rate_mask = sad_ff[1][6:0];
               rec.coding_format = {1'b0, fmt};
               if (fmt == FMT_LPCM) begin
                  rec.sample_size_mask = b[2:0];
               end else if (fmt >= FMT_COMP_LO && fmt <= FMT_COMP_HI) begin
                  rec.peak_bitrate = {13'd0, b} * BITRATE_UNIT;
               end else if (fmt == FMT_WMAPRO) begin
                  rec.profile = b[2:0];
               end else if (fmt == FMT_EXTENDED) begin
                  rec.coding_format = (ext >= EXT_FIRST && ext <= EXT_LAST) ?
                                      ext + EXT_OFFSET : 5'd0;
               end
            end
         end else begin
            phase_in = phase_ff + 2'd1;
         end
      end

      if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 8'd1;
      end

      need = 7'(FIXED_BYTES) + {2'd0, nl_in} + {2'd0, cnt_in, 1'b0} + {3'd0, cnt_in};
      final_stat = err_in;
      if (err_in == STAT_OK && pos_in < {1'b0, need}) begin
         final_stat = STAT_TRUNCATED;
      end
      stat_rec = '0;
      stat_rec.record_kind = KIND_STATUS;
      stat_rec.status = final_stat;
      stat_rec.last_out = 1'b1;

      first_rec = has_rec ? rec : stat_rec;
      push_n = accept ? ({1'b0, has_rec} + {1'b0, req_tlast}) : 2'd0;

      if (accept && req_tlast) begin
         pos_in   = '0;
         nl_in    = '0;
         cnt_in   = '0;
         done_in  = '0;
         phase_in = '0;
         err_in   = STAT_OK;
         id_in    = '0;
      end else if (!accept) begin
         pos_in   = pos_ff;
         nl_in    = nl_ff;
         cnt_in   = cnt_ff;
         done_in  = done_ff;
         phase_in = phase_ff;
         err_in   = err_ff;
         id_in    = id_ff;
      end

      wr_ptr_in = wr_ptr_ff + FIFO_AW'(push_n);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         nl_ff     <= '0;
         cnt_ff    <= '0;
         done_ff   <= '0;
         phase_ff  <= '0;
         err_ff    <= STAT_OK;
         id_ff     <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         pos_ff    <= pos_in;
         nl_ff     <= nl_in;
         cnt_ff    <= cnt_in;
         done_ff   <= done_in;
         phase_ff  <= phase_in;
         err_ff    <= err_in;
         id_ff     <= id_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, no reset needed.
   always_ff @(posedge clock) begin
      if (accept && pos_ff < POS_ID_LO) begin
         hdr_ff[pos_ff[2:0]] <= b;
      end
      if (accept && pos_ff >= POS_SAD && sad_act && phase_ff != 2'd2) begin
         sad_ff[phase_ff[0]] <= b;
      end
      if (push_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= first_rec;
      end
      if (push_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= stat_rec;
      end
   end

   `ELD_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1,
      count_ff <= (FIFO_AW+1)'(FIFO_DEPTH), "result queue overflow")
   `ELD_ASSERT_NOW(a_sad_count, clock, reset, 1'b1,
      done_ff <= cnt_ff, "more SADs decoded than announced")
   `ELD_ASSERT_NEXT(a_restart, clock, reset, accept && req_tlast,
      pos_ff == 8'd0 && err_ff == STAT_OK && done_ff == 4'd0, "parser not reset after final byte")
   `ELD_ASSERT_NEXT(a_err_sticky, clock, reset, err_ff != STAT_OK && !(accept && req_tlast),
      err_ff == $past(err_ff), "error code changed before end of buffer")

endmodule

`default_nettype wire
